[design/grid_maze_depth_first_carver_defines.svh]
// Assertion macros for the grid maze carver.
// Depends on nothing; the using module must provide the signals clk and arst_n.
`ifndef GRID_MAZE_DEPTH_FIRST_CARVER_DEFINES_SVH
`define GRID_MAZE_DEPTH_FIRST_CARVER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GMDC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gmdc: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GMDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gmdc: next-cycle check failed");

`endif

[design/gmdc_pkg.sv]
// Shared types, constants, helper functions and the microcode ROM of the maze carver.
// Depends on nothing; used by the channel interface users and the top level.
package gmdc_pkg;

	localparam int DEF_MAX_ROWS  = 32;
	localparam int DEF_MAX_COLS  = 32;
	localparam int CFG_W         = 6;
	localparam int CFG_IDX_W     = 1;
	localparam int DIM_W         = 7;
	localparam int ROW_W         = 5;
	localparam int COL_W         = 5;
	localparam int RAND_W        = 16;
	localparam int EVENT_W       = 3;
	localparam int STACK_DEPTH_W = 11;
	localparam int UADDR_W       = 5;

	localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;
	localparam logic [CFG_W-1:0]     GRID_DIM_RESET = 6'd30;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_STEP  = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [EVENT_W-1:0] EV_CARVED = 3'd0;
	localparam logic [EVENT_W-1:0] EV_BACK   = 3'd1;
	localparam logic [EVENT_W-1:0] EV_DONE   = 3'd2;
	localparam logic [EVENT_W-1:0] EV_REJECT = 3'd3;
	localparam logic [EVENT_W-1:0] EV_WALLS  = 3'd4;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic [3:0] WALL_UP    = 4'b0001;
	localparam logic [3:0] WALL_RIGHT = 4'b0010;
	localparam logic [3:0] WALL_DOWN  = 4'b0100;
	localparam logic [3:0] WALL_LEFT  = 4'b1000;
	localparam logic [3:0] WALL_ALL   = WALL_UP | WALL_RIGHT | WALL_DOWN | WALL_LEFT;

	typedef struct packed {
		logic [1:0]        command;
		logic [ROW_W-1:0]  cell_row;
		logic [COL_W-1:0]  cell_col;
		logic [RAND_W-1:0] random_value;
	} cmd_item_t;

	typedef struct packed {
		logic [EVENT_W-1:0]       event_res;
		logic [ROW_W-1:0]         out_row;
		logic [COL_W-1:0]         out_col;
		logic [1:0]               carve_direction;
		logic [3:0]               wall_bits;
		logic [STACK_DEPTH_W-1:0] stack_depth;
	} res_item_t;

	typedef struct packed {
		logic       visited;
		logic [3:0] walls;
	} cell_t;

	typedef logic [UADDR_W-1:0] uaddr_t;

	typedef enum logic [3:0] {
		MEM_NONE,
		MEM_RD_IN,
		MEM_RD_TOP,
		MEM_RD_NB,
		MEM_RD_DIR,
		MEM_CLR,
		MEM_WR_START,
		MEM_WR_TOP,
		MEM_WR_NB
	} mem_op_t;

	typedef enum logic [3:0] {
		DP_NONE,
		DP_REJECT,
		DP_POST,
		DP_START,
		DP_READ,
		DP_STK_RD,
		DP_LD_TOP,
		DP_CAND,
		DP_PICK,
		DP_CARVE,
		DP_PUSH,
		DP_POP
	} dp_op_t;

	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_ACCEPT,
		C_CMD_START,
		C_CMD_READ,
		C_CMD_STEP,
		C_CELL_OUT,
		C_STACK_EMPTY,
		C_CLEAR_MORE,
		C_NO_CARVE
	} cond_t;

	typedef struct packed {
		logic       take;
		mem_op_t    mem;
		logic [1:0] nb;
		dp_op_t     dp;
		cond_t      cond;
		uaddr_t     tgt;
	} ctrl_t;

	// Microprogram addresses.
	localparam uaddr_t U_IDLE        = 5'd0;
	localparam uaddr_t U_DISP_START  = 5'd1;
	localparam uaddr_t U_DISP_READ   = 5'd2;
	localparam uaddr_t U_DISP_STEP   = 5'd3;
	localparam uaddr_t U_REJECT      = 5'd4;
	localparam uaddr_t U_EMIT        = 5'd5;
	localparam uaddr_t U_START       = 5'd6;
	localparam uaddr_t U_CLEAR       = 5'd7;
	localparam uaddr_t U_PLANT       = 5'd8;
	localparam uaddr_t U_READ        = 5'd9;
	localparam uaddr_t U_READ_MEM    = 5'd10;
	localparam uaddr_t U_READ_RES    = 5'd11;
	localparam uaddr_t U_STEP        = 5'd12;
	localparam uaddr_t U_STK         = 5'd13;
	localparam uaddr_t U_TOP         = 5'd14;
	localparam uaddr_t U_PROBE_UP    = 5'd15;
	localparam uaddr_t U_PROBE_RIGHT = 5'd16;
	localparam uaddr_t U_PROBE_DOWN  = 5'd17;
	localparam uaddr_t U_PROBE_LEFT  = 5'd18;
	localparam uaddr_t U_RD_TOP      = 5'd19;
	localparam uaddr_t U_PICK        = 5'd20;
	localparam uaddr_t U_DECIDE      = 5'd21;
	localparam uaddr_t U_CARVE       = 5'd22;
	localparam uaddr_t U_PUSH        = 5'd23;
	localparam uaddr_t U_POP         = 5'd24;
	localparam uaddr_t U_BOOT        = 5'd25;
	localparam uaddr_t U_BOOT_END    = 5'd26;

	// A register value of zero counts as one, anything above the maximum as the maximum.
	function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] ext;
		ext = DIM_W'(v);
		if (v == '0) begin
			return DIM_W'(1);
		end
		return (ext > maxv) ? maxv : ext;
	endfunction

	function automatic logic [3:0] own_wall(input logic [1:0] d);
		logic [3:0] w;
		case (d)
			DIR_UP:    w = WALL_UP;
			DIR_RIGHT: w = WALL_RIGHT;
			DIR_DOWN:  w = WALL_DOWN;
			default:   w = WALL_LEFT;
		endcase
		return w;
	endfunction

	function automatic logic [3:0] far_wall(input logic [1:0] d);
		logic [3:0] w;
		case (d)
			DIR_UP:    w = WALL_DOWN;
			DIR_RIGHT: w = WALL_LEFT;
			DIR_DOWN:  w = WALL_UP;
			default:   w = WALL_RIGHT;
		endcase
		return w;
	endfunction

	// Remainder by three: since four is one modulo three, base-four digits are summed.
	function automatic logic [1:0] mod3(input logic [RAND_W-1:0] v);
		logic [4:0] s;
		logic [2:0] s2;
		logic [2:0] t;
		s = '0;
		for (int i = 0; i < RAND_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		s2 = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
		t = 3'(s2[1:0]) + 3'(s2[2]);
		return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
	endfunction

	// Random choice among the open neighbors, in the fixed up, right, down, left order.
	function automatic logic [1:0] pick_dir(input logic [3:0] cand,
			input logic [RAND_W-1:0] rnd);
		logic [2:0] count;
		logic [1:0] k;
		logic [1:0] seen;
		logic       found;
		logic [1:0] dir;
		count = 3'($countones(cand));
		case (count)
			3'd2:    k = {1'b0, rnd[0]};
			3'd3:    k = mod3(rnd);
			3'd4:    k = rnd[1:0];
			default: k = '0;
		endcase
		seen  = '0;
		found = 1'b0;
		dir   = '0;
		for (int i = 0; i < 4; i++) begin
			if (cand[i]) begin
				if (!found && seen == k) begin
					dir   = 2'(i);
					found = 1'b1;
				end
				seen = seen + 2'd1;
			end
		end
		return dir;
	endfunction

	function automatic ctrl_t uword(input logic take, input mem_op_t mem, input logic [1:0] nb,
			input dp_op_t dp, input cond_t cond, input uaddr_t tgt);
		ctrl_t w;
		w.take = take;
		w.mem  = mem;
		w.nb   = nb;
		w.dp   = dp;
		w.cond = cond;
		w.tgt  = tgt;
		return w;
	endfunction

	// The control store. A true condition jumps to the target, otherwise the
	// sequencer steps to the next word; a post word holds while the output is blocked.
	function automatic ctrl_t ucode(input uaddr_t a);
		ctrl_t w;
		case (a)
			U_IDLE:        w = uword(1'b1, MEM_NONE, DIR_UP, DP_NONE, C_NO_ACCEPT, U_IDLE);
			U_DISP_START:  w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_CMD_START, U_START);
			U_DISP_READ:   w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_CMD_READ, U_READ);
			U_DISP_STEP:   w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_CMD_STEP, U_STEP);
			U_REJECT:      w = uword(1'b0, MEM_NONE, DIR_UP, DP_REJECT, C_ALWAYS, U_EMIT);
			U_EMIT:        w = uword(1'b0, MEM_NONE, DIR_UP, DP_POST, C_ALWAYS, U_IDLE);
			U_START:       w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_CELL_OUT, U_REJECT);
			U_CLEAR:       w = uword(1'b0, MEM_CLR, DIR_UP, DP_NONE, C_CLEAR_MORE, U_CLEAR);
			U_PLANT:       w = uword(1'b0, MEM_WR_START, DIR_UP, DP_START, C_ALWAYS, U_EMIT);
			U_READ:        w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_CELL_OUT, U_REJECT);
			U_READ_MEM:    w = uword(1'b0, MEM_RD_IN, DIR_UP, DP_NONE, C_NEXT, U_IDLE);
			U_READ_RES:    w = uword(1'b0, MEM_NONE, DIR_UP, DP_READ, C_ALWAYS, U_EMIT);
			U_STEP:        w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_STACK_EMPTY, U_REJECT);
			U_STK:         w = uword(1'b0, MEM_NONE, DIR_UP, DP_STK_RD, C_NEXT, U_IDLE);
			U_TOP:         w = uword(1'b0, MEM_NONE, DIR_UP, DP_LD_TOP, C_NEXT, U_IDLE);
			U_PROBE_UP:    w = uword(1'b0, MEM_RD_NB, DIR_UP, DP_NONE, C_NEXT, U_IDLE);
			U_PROBE_RIGHT: w = uword(1'b0, MEM_RD_NB, DIR_RIGHT, DP_CAND, C_NEXT, U_IDLE);
			U_PROBE_DOWN:  w = uword(1'b0, MEM_RD_NB, DIR_DOWN, DP_CAND, C_NEXT, U_IDLE);
			U_PROBE_LEFT:  w = uword(1'b0, MEM_RD_NB, DIR_LEFT, DP_CAND, C_NEXT, U_IDLE);
			U_RD_TOP:      w = uword(1'b0, MEM_RD_TOP, DIR_UP, DP_CAND, C_NEXT, U_IDLE);
			U_PICK:        w = uword(1'b0, MEM_NONE, DIR_UP, DP_PICK, C_NEXT, U_IDLE);
			U_DECIDE:      w = uword(1'b0, MEM_RD_DIR, DIR_UP, DP_NONE, C_NO_CARVE, U_POP);
			U_CARVE:       w = uword(1'b0, MEM_WR_TOP, DIR_UP, DP_CARVE, C_NEXT, U_IDLE);
			U_PUSH:        w = uword(1'b0, MEM_WR_NB, DIR_UP, DP_PUSH, C_ALWAYS, U_EMIT);
			U_POP:         w = uword(1'b0, MEM_NONE, DIR_UP, DP_POP, C_ALWAYS, U_EMIT);
			U_BOOT:        w = uword(1'b0, MEM_CLR, DIR_UP, DP_NONE, C_CLEAR_MORE, U_BOOT);
			U_BOOT_END:    w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_ALWAYS, U_IDLE);
			default:       w = uword(1'b0, MEM_NONE, DIR_UP, DP_NONE, C_ALWAYS, U_IDLE);
		endcase
		return w;
	endfunction

endpackage

[design/gmdc_chan_if.sv]
// Valid/ready channel interface carrying one payload struct per transaction.
// Depends on nothing; the payload type is set by the instantiating code.
interface gmdc_chan_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/grid_maze_depth_first_carver.sv]
// Top level of the depth-first maze carver: sequencer, cell memory and path stack.
// Depends on gmdc_pkg, gmdc_chan_if and grid_maze_depth_first_carver_defines.svh.
`include "grid_maze_depth_first_carver_defines.svh"

// Depth-first maze carver. Commands arrive as transactions on cmds and each one
// yields exactly one result transaction on results. The block is run by a small
// microprogram over a single-port cell memory (visited mark plus four walls per
// cell) and a path stack memory, so it works on one command at a time: a step
// reads the stack top, then probes the four neighbors and the top cell in turn
// over the one cell memory port, and a carving step adds the two wall writes that
// share that port; a wall read issues one cell read, and a rejected command is
// answered as soon as the command dispatch rejects it.
// A start command sweeps the whole cell memory, one cell per cycle, before it
// plants the start cell. After reset the same sweep runs once before the first
// command transaction is taken; configuration writes are taken at any time. A
// finished result sits in an output register, so the next command is accepted
// while the previous result waits to be taken. Grid size registers are written
// through cfg_we, cfg_index and cfg_data and should only change while no
// command is in flight.
module grid_maze_depth_first_carver #(
	parameter int MAX_ROWS = gmdc_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = gmdc_pkg::DEF_MAX_COLS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	gmdc_chan_if.sink                      cmds,
	gmdc_chan_if.source                    results,
	input  logic                           cfg_we,
	input  logic [gmdc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gmdc_pkg::CFG_W-1:0]     cfg_data
);
	import gmdc_pkg::*;

	// Cells are addressed by {row, col}, which keeps every address a plain concatenation.
	localparam int RW        = $clog2(MAX_ROWS);
	localparam int CW        = $clog2(MAX_COLS);
	localparam int AW        = RW + CW;
	localparam int MEM_DEPTH = 2 ** AW;
	localparam int NCELLS    = MAX_ROWS * MAX_COLS;
	localparam int SAW       = $clog2(NCELLS);
	localparam int SPW       = $clog2(NCELLS + 1);

	// Sequencer.
	uaddr_t upc_q;
	uaddr_t upc_d;
	ctrl_t  ctrl;
	logic   cond_true;

	// Configuration.
	logic [CFG_W-1:0] rows_q;
	logic [CFG_W-1:0] cols_q;
	logic [DIM_W-1:0] rows_eff;
	logic [DIM_W-1:0] cols_eff;

	// Datapath registers.
	cmd_item_t      item_q;
	logic [SPW-1:0] sp_q;
	logic [AW-1:0]  clr_addr_q;
	logic [RW-1:0]  top_r_q;
	logic [CW-1:0]  top_c_q;
	logic [1:0]     rd_dir_q;
	logic [1:0]     dir_q;
	logic [3:0]     cand_q;
	logic           carve_q;
	logic [3:0]     top_walls_q;
	cell_t          rdata_q;
	logic [AW-1:0]  stk_rdata_q;

	// Staged result and the output register.
	logic [EVENT_W-1:0] res_ev_q;
	logic [ROW_W-1:0]   res_row_q;
	logic [COL_W-1:0]   res_col_q;
	logic [1:0]         res_dir_q;
	logic [3:0]         res_walls_q;
	res_item_t          out_q;
	logic               out_valid_q;

	// Memories.
	cell_t         cell_mem [MEM_DEPTH];
	logic [AW-1:0] stk_mem [NCELLS];

	// Combinational datapath signals.
	logic          accept_in;
	logic          out_blocked;
	logic          post_fire;
	logic          cell_outside;
	logic [AW-1:0] in_addr;
	logic [AW-1:0] top_addr;
	logic [AW-1:0] nb_addr [4];
	logic [3:0]    inb;
	logic          mem_re;
	logic          mem_we;
	logic [AW-1:0] mem_raddr;
	logic [AW-1:0] mem_waddr;
	cell_t         mem_wdata;
	logic          stk_re;
	logic          stk_we;
	logic [SAW-1:0] stk_waddr;
	logic [AW-1:0] stk_wdata;

	assign cmds.ready    = ctrl.take;
	assign accept_in     = cmds.valid && cmds.ready;
	assign results.valid = out_valid_q;
	assign results.data  = out_q;
	assign out_blocked   = out_valid_q && !results.ready;
	assign post_fire     = (ctrl.dp == DP_POST) && !out_blocked;

	assign rows_eff = eff_dim(rows_q, DIM_W'(MAX_ROWS));
	assign cols_eff = eff_dim(cols_q, DIM_W'(MAX_COLS));

	// The command's cell is only ever used for the memory when it lies inside the grid.
	assign cell_outside = (DIM_W'(item_q.cell_row) >= rows_eff) ||
	                      (DIM_W'(item_q.cell_col) >= cols_eff);
	assign in_addr  = {RW'(item_q.cell_row), CW'(item_q.cell_col)};
	assign top_addr = {top_r_q, top_c_q};

	// Neighbor addresses may wrap at the edge; such neighbors are masked by inb.
	assign nb_addr[DIR_UP]    = {top_r_q + RW'(1), top_c_q};
	assign nb_addr[DIR_RIGHT] = {top_r_q, top_c_q + CW'(1)};
	assign nb_addr[DIR_DOWN]  = {top_r_q - RW'(1), top_c_q};
	assign nb_addr[DIR_LEFT]  = {top_r_q, top_c_q - CW'(1)};

	// A cell pushed before the grid shrank still carves only into the grid in use,
	// so both coordinates of every neighbor are checked against the grid.
	assign inb[DIR_UP]    = ((DIM_W'(top_r_q) + DIM_W'(1)) < rows_eff) &&
	                        (DIM_W'(top_c_q) < cols_eff);
	assign inb[DIR_RIGHT] = (DIM_W'(top_r_q) < rows_eff) &&
	                        ((DIM_W'(top_c_q) + DIM_W'(1)) < cols_eff);
	assign inb[DIR_DOWN]  = (top_r_q != '0) && (DIM_W'(top_r_q) <= rows_eff) &&
	                        (DIM_W'(top_c_q) < cols_eff);
	assign inb[DIR_LEFT]  = (top_c_q != '0) && (DIM_W'(top_c_q) <= cols_eff) &&
	                        (DIM_W'(top_r_q) < rows_eff);

	// Control word for the current step.
	always_comb begin
		ctrl = ucode(upc_q);
	end

	// Branch condition of the current word.
	always_comb begin
		case (ctrl.cond)
			C_NEXT:        cond_true = 1'b0;
			C_ALWAYS:      cond_true = 1'b1;
			C_NO_ACCEPT:   cond_true = !accept_in;
			C_CMD_START:   cond_true = item_q.command == CMD_START;
			C_CMD_READ:    cond_true = item_q.command == CMD_READ;
			C_CMD_STEP:    cond_true = item_q.command == CMD_STEP;
			C_CELL_OUT:    cond_true = cell_outside;
			C_STACK_EMPTY: cond_true = sp_q == '0;
			C_CLEAR_MORE:  cond_true = clr_addr_q != '1;
			C_NO_CARVE:    cond_true = !carve_q;
			default:       cond_true = 1'b0;
		endcase
	end

	// Next step: the post word holds while the output register is still occupied.
	always_comb begin
		if ((ctrl.dp == DP_POST) && out_blocked) begin
			upc_d = upc_q;
		end else if (cond_true) begin
			upc_d = ctrl.tgt;
		end else begin
			upc_d = upc_q + UADDR_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= U_BOOT;
		end else begin
			upc_q <= upc_d;
		end
	end

	// Memory port decode from the control word.
	always_comb begin
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_raddr = top_addr;
		mem_waddr = top_addr;
		mem_wdata = '{visited: 1'b1, walls: top_walls_q & ~own_wall(dir_q)};
		case (ctrl.mem)
			MEM_NONE: begin
			end
			MEM_RD_IN: begin
				mem_re    = 1'b1;
				mem_raddr = in_addr;
			end
			MEM_RD_TOP: begin
				mem_re = 1'b1;
			end
			MEM_RD_NB: begin
				mem_re    = 1'b1;
				mem_raddr = nb_addr[ctrl.nb];
			end
			MEM_RD_DIR: begin
				mem_re    = 1'b1;
				mem_raddr = nb_addr[dir_q];
			end
			MEM_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = '{visited: 1'b0, walls: WALL_ALL};
			end
			MEM_WR_START: begin
				mem_we    = 1'b1;
				mem_waddr = in_addr;
				mem_wdata = '{visited: 1'b1, walls: WALL_ALL};
			end
			MEM_WR_TOP: begin
				mem_we = 1'b1;
			end
			MEM_WR_NB: begin
				mem_we    = 1'b1;
				mem_waddr = nb_addr[dir_q];
				mem_wdata = '{visited: 1'b1, walls: rdata_q.walls & ~far_wall(dir_q)};
			end
			default: begin
			end
		endcase
	end

	// Path stack port decode.
	assign stk_re    = ctrl.dp == DP_STK_RD;
	assign stk_we    = (ctrl.dp == DP_START) || (ctrl.dp == DP_PUSH);
	assign stk_waddr = (ctrl.dp == DP_START) ? '0 : SAW'(sp_q);
	assign stk_wdata = (ctrl.dp == DP_START) ? in_addr : nb_addr[dir_q];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			cell_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= cell_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_waddr] <= stk_wdata;
		end
		if (stk_re) begin
			stk_rdata_q <= stk_mem[SAW'(sp_q - SPW'(1))];
		end
	end

	// Grid size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= GRID_DIM_RESET;
			cols_q <= GRID_DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_GRID_ROWS) begin
				rows_q <= cfg_data;
			end
			if (cfg_index == REG_GRID_COLS) begin
				cols_q <= cfg_data;
			end
		end
	end

	// Control state: stack pointer, clearing sweep address and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The sweep ends on the last address and wraps back to zero for the next one.
			if (ctrl.mem == MEM_CLR) begin
				clr_addr_q <= clr_addr_q + AW'(1);
			end
			case (ctrl.dp)
				DP_START: sp_q <= SPW'(1);
				DP_PUSH:  sp_q <= sp_q + SPW'(1);
				DP_POP:   sp_q <= sp_q - SPW'(1);
				default: begin
				end
			endcase
			if (post_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		if (accept_in) begin
			item_q <= cmds.data;
		end
		if (ctrl.mem == MEM_RD_NB) begin
			rd_dir_q <= ctrl.nb;
		end
		case (ctrl.dp)
			DP_REJECT: begin
				res_ev_q    <= EV_REJECT;
				res_row_q   <= '0;
				res_col_q   <= '0;
				res_dir_q   <= '0;
				res_walls_q <= '0;
			end
			DP_START: begin
				res_ev_q    <= EV_REJECT;
				res_row_q   <= item_q.cell_row;
				res_col_q   <= item_q.cell_col;
				res_dir_q   <= '0;
				res_walls_q <= WALL_ALL;
			end
			DP_READ: begin
				res_ev_q    <= EV_WALLS;
				res_row_q   <= item_q.cell_row;
				res_col_q   <= item_q.cell_col;
				res_dir_q   <= '0;
				res_walls_q <= rdata_q.walls;
			end
			DP_LD_TOP: begin
				top_r_q <= stk_rdata_q[AW-1:CW];
				top_c_q <= stk_rdata_q[CW-1:0];
			end
			DP_CAND: begin
				// The data of the probe issued in the previous step is now in rdata_q.
				cand_q[rd_dir_q] <= inb[rd_dir_q] && !rdata_q.visited;
			end
			DP_PICK: begin
				top_walls_q <= rdata_q.walls;
				dir_q       <= pick_dir(cand_q, item_q.random_value);
				carve_q     <= (cand_q != '0) && (sp_q < SPW'(NCELLS));
			end
			DP_CARVE: begin
				res_ev_q    <= EV_CARVED;
				res_row_q   <= ROW_W'(top_r_q);
				res_col_q   <= COL_W'(top_c_q);
				res_dir_q   <= dir_q;
				res_walls_q <= top_walls_q & ~own_wall(dir_q);
			end
			DP_POP: begin
				res_ev_q    <= (sp_q == SPW'(1)) ? EV_DONE : EV_BACK;
				res_row_q   <= ROW_W'(top_r_q);
				res_col_q   <= COL_W'(top_c_q);
				res_dir_q   <= '0;
				res_walls_q <= top_walls_q;
			end
			default: begin
			end
		endcase
		if (post_fire) begin
			out_q.event_res       <= res_ev_q;
			out_q.out_row         <= res_row_q;
			out_q.out_col         <= res_col_q;
			out_q.carve_direction <= res_dir_q;
			out_q.wall_bits       <= res_walls_q;
			out_q.stack_depth     <= STACK_DEPTH_W'(sp_q);
		end
	end

	`GMDC_ASSERT_NEXT(a_accept_dispatches, accept_in, upc_q == U_DISP_START)
	`GMDC_ASSERT_NOW(a_carve_is_open, ctrl.dp == DP_CARVE, cand_q[dir_q])
	`GMDC_ASSERT_NEXT(a_push_grows, ctrl.dp == DP_PUSH, sp_q == $past(sp_q) + SPW'(1))
	`GMDC_ASSERT_NOW(a_pop_nonempty, ctrl.dp == DP_POP, sp_q != '0)

endmodule
